// ===== hw/rtl/dsdp_pkg.sv =====
// shared types, mode and register codes, and helper functions of the dsd word packer
`default_nettype none

package dsdp_pkg;

	localparam int MAX_CHANNELS_DEF = 8;
	localparam int QUEUE_DEPTH      = 2;
	localparam int CFG_AW           = 4;

	localparam logic [7:0] DOP_MARKER_INIT = 8'h05;

	localparam logic [2:0] MODE_MSB8      = 3'd0;
	localparam logic [2:0] MODE_LSB8      = 3'd1;
	localparam logic [2:0] MODE_DSD16     = 3'd2;
	localparam logic [2:0] MODE_DSD24     = 3'd3;
	localparam logic [2:0] MODE_DSD32     = 3'd4;
	localparam logic [2:0] MODE_DOP24IN32 = 3'd5;
	localparam logic [2:0] MODE_DOP32     = 3'd6;
	localparam logic [2:0] MODE_DOP24P    = 3'd7;

	localparam logic [1:0] REG_PACK_MODE     = 2'd0;
	localparam logic [1:0] REG_BIG_ENDIAN    = 2'd1;
	localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

	localparam logic [3:0] NIBBLE_REV [16] = '{
		4'h0, 4'h8, 4'h4, 4'hc, 4'h2, 4'ha, 4'h6, 4'he,
		4'h1, 4'h9, 4'h5, 4'hd, 4'h3, 4'hb, 4'h7, 4'hf
	};

	// one queue entry's control part; the group bytes travel beside it
	typedef struct packed {
		logic [2:0] mode;
		logic       big_endian;
		logic [3:0] chn;
		logic [7:0] marker;
		logic [2:0] chan;
	} job_t;

	function automatic logic [7:0] rev_byte(input logic [7:0] b);
		return {NIBBLE_REV[b[3:0]], NIBBLE_REV[b[7:4]]};
	endfunction

	// dsd bytes per channel word in the grouped modes
	function automatic logic [2:0] mode_width(input logic [2:0] mode);
		logic [2:0] w;
		case (mode)
			MODE_DSD24: w = 3'd3;
			MODE_DSD32: w = 3'd4;
			default:    w = 3'd2;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dsdp_front.sv =====
// front end: takes stream bytes, fills the group buffer and queues finished groups and passthrough bytes
`default_nettype none

module dsdp_front
	import dsdp_pkg::*;
#(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        accept,
	input  wire logic [7:0]                  dsd_byte,
	input  wire logic                        buffer_start,
	input  wire logic [2:0]                  pack_mode,
	input  wire logic                        big_endian,
	input  wire logic [3:0]                  channel_count,
	output logic                             push,
	output job_t                             push_job,
	output logic [8*4*MAX_CHANNELS-1:0]      push_snap
);

	localparam int GRP_DEPTH = 4 * MAX_CHANNELS;
	localparam int AW        = $clog2(GRP_DEPTH);
	localparam int SZ_W      = $clog2(GRP_DEPTH + 1);
	localparam int CW        = (SZ_W > 4) ? SZ_W : 4;

	logic [AW-1:0] pos_q, pos0, pos_d;
	logic [7:0]    marker_q, marker0, marker_d;
	logic [7:0]    grp_q [GRP_DEPTH];
	logic [3:0]    chn;
	logic [2:0]    width;
	logic          passthru;
	logic          complete;
	logic [CW-1:0] pos_x, chn_x, size_x, kx, k1, pos1;

	always_comb begin
		if (channel_count == 4'd0) begin
			chn = 4'd1;
		end else if (channel_count > 4'(MAX_CHANNELS)) begin
			chn = 4'(MAX_CHANNELS);
		end else begin
			chn = channel_count;
		end
	end

	assign passthru = pack_mode inside {MODE_MSB8, MODE_LSB8};
	assign width    = mode_width(pack_mode);
	assign pos0     = buffer_start ? '0 : pos_q;
	assign marker0  = buffer_start ? DOP_MARKER_INIT : marker_q;

	assign pos_x  = CW'(pos0);
	assign chn_x  = CW'(chn);
	assign size_x = CW'(width) * chn_x;
	assign kx     = (pos_x >= chn_x) ? '0 : pos_x;
	assign k1     = kx + CW'(1);
	assign pos1   = pos_x + CW'(1);
	assign complete = pos1 >= size_x;

	always_comb begin
		if (passthru) begin
			pos_d    = (k1 >= chn_x) ? '0 : k1[AW-1:0];
			marker_d = marker0;
		end else begin
			pos_d    = complete ? '0 : pos1[AW-1:0];
			marker_d = complete ? ~marker0 : marker0;
		end
	end

	assign push = accept && (passthru || complete);

	always_comb begin
		push_job.mode       = pack_mode;
		push_job.big_endian = big_endian;
		push_job.chn        = chn;
		push_job.marker     = marker0;
		push_job.chan       = passthru ? kx[2:0] : 3'd0;
	end

	// snapshot of the buffer as it stands after this byte is written (into slot 0 in passthrough modes)
	always_comb begin
		for (int j = 0; j < GRP_DEPTH; j++) begin
			if ((passthru && j == 0) || (!passthru && pos0 == AW'(j))) begin
				push_snap[8*j +: 8] = dsd_byte;
			end else begin
				push_snap[8*j +: 8] = grp_q[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			marker_q <= DOP_MARKER_INIT;
		end else if (accept) begin
			pos_q    <= pos_d;
			marker_q <= marker_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !passthru) begin
			grp_q[pos0] <= dsd_byte;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/dsdp_fifo.sv =====
// short queue of finished groups and passthrough words between front and back
`default_nettype none

module dsdp_fifo
	import dsdp_pkg::*;
#(
	parameter int W     = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	input  wire logic         pop,
	output logic [W-1:0]      head_data,
	output logic              empty,
	output logic              full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [NW-1:0] count_q;

	assign head_data = mem_q[rd_ptr_q];
	assign empty     = count_q == '0;
	assign full      = count_q == NW'(DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== hw/rtl/dsdp_back.sv =====
// back end: gathers each channel's bytes from the queued group and emits one word per channel
`default_nettype none

module dsdp_back
	import dsdp_pkg::*;
#(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        head_valid,
	input  wire job_t                        head_job,
	input  wire logic [8*4*MAX_CHANNELS-1:0] head_snap,
	output logic                             pop,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [31:0]                      out_bytes,
	output logic [2:0]                       out_byte_count,
	output logic [2:0]                       out_channel,
	output logic                             last
);

	localparam int GRP_DEPTH = 4 * MAX_CHANNELS;
	localparam int AW        = $clog2(GRP_DEPTH);
	localparam int SZ_W      = $clog2(GRP_DEPTH + 1);
	localparam int CW        = (SZ_W > 4) ? SZ_W : 4;

	typedef struct packed {
		logic [31:0] bytes;
		logic [2:0]  count;
	} word_t;

	function automatic word_t build_word(input logic [2:0] mode, input logic be,
		input logic [7:0] m, input logic [7:0] s0, input logic [7:0] s1,
		input logic [7:0] s2, input logic [7:0] s3);
		word_t w;
		case (mode)
			MODE_DSD16: begin
				w.bytes = be ? {16'd0, s1, s0} : {16'd0, s0, s1};
				w.count = 3'd2;
			end
			MODE_DSD24: begin
				w.bytes = be ? {8'd0, s2, s1, s0} : {8'd0, s0, s1, s2};
				w.count = 3'd3;
			end
			MODE_DSD32: begin
				w.bytes = be ? {s3, s2, s1, s0} : {s0, s1, s2, s3};
				w.count = 3'd4;
			end
			MODE_DOP24IN32: begin
				w.bytes = be ? {s1, s0, m, 8'd0} : {8'd0, m, s0, s1};
				w.count = 3'd4;
			end
			MODE_DOP32: begin
				w.bytes = be ? {8'd0, s1, s0, m} : {m, s0, s1, 8'd0};
				w.count = 3'd4;
			end
			MODE_DOP24P: begin
				w.bytes = be ? {8'd0, s1, s0, m} : {8'd0, m, s0, s1};
				w.count = 3'd3;
			end
			default: begin
				w.bytes = {24'd0, s0};
				w.count = 3'd1;
			end
		endcase
		return w;
	endfunction

	logic [2:0]    c_q, c_next;
	logic [1:0]    i_q;
	logic [AW-1:0] addr_q;
	logic [7:0]    s_q [3];
	logic [7:0]    s_cur [4];
	logic [7:0]    rd_byte;
	logic [2:0]    width;
	logic          passthru;
	logic          last_byte;
	logic          last_word;
	logic          out_free;
	logic          load;
	logic          advance;
	logic [CW-1:0] addr_sum;
	logic [CW-1:0] grp_size;
	word_t         grp_word;

	logic          out_valid_q;
	logic [31:0]   out_bytes_q;
	logic [2:0]    out_count_q;
	logic [2:0]    out_chan_q;
	logic          out_last_q;

	assign passthru  = head_job.mode inside {MODE_MSB8, MODE_LSB8};
	assign width     = mode_width(head_job.mode);
	assign rd_byte   = head_snap[{addr_q, 3'b000} +: 8];
	assign last_byte = ({1'b0, i_q} + 3'd1) == width;
	assign c_next    = c_q + 3'd1;
	assign last_word = passthru || ({1'b0, c_q} + 4'd1 == head_job.chn);
	assign addr_sum  = CW'(addr_q) + CW'(head_job.chn);
	assign grp_size  = CW'(width) * CW'(head_job.chn);

	always_comb begin
		for (int n = 0; n < 3; n++) begin
			s_cur[n] = (i_q == 2'(n)) ? rd_byte : s_q[n];
		end
		s_cur[3] = rd_byte;
	end

	assign grp_word = build_word(head_job.mode, head_job.big_endian, head_job.marker,
		s_cur[0], s_cur[1], s_cur[2], s_cur[3]);

	assign out_free = !out_valid_q || out_ready;
	assign load     = head_valid && (passthru || last_byte) && out_free;
	assign advance  = head_valid && !passthru && !last_byte;
	assign pop      = load && last_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q    <= '0;
			i_q    <= '0;
			addr_q <= '0;
		end else if (advance) begin
			i_q    <= i_q + 2'd1;
			addr_q <= addr_sum[AW-1:0];
		end else if (load && !passthru) begin
			i_q <= '0;
			if (last_word) begin
				c_q    <= '0;
				addr_q <= '0;
			end else begin
				c_q    <= c_next;
				addr_q <= AW'(c_next);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			s_q[i_q] <= rd_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (passthru) begin
				out_bytes_q <= {24'd0, (head_job.mode == MODE_LSB8) ?
					rev_byte(head_snap[7:0]) : head_snap[7:0]};
				out_count_q <= 3'd1;
				out_chan_q  <= head_job.chan;
			end else begin
				out_bytes_q <= grp_word.bytes;
				out_count_q <= grp_word.count;
				out_chan_q  <= c_q;
			end
			out_last_q <= last_word;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_bytes      = out_bytes_q;
	assign out_byte_count = out_count_q;
	assign out_channel    = out_chan_q;
	assign last           = out_last_q;

	a_chan_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid && !passthru |-> {1'b0, c_q} < head_job.chn)
		else $error("channel counter past group channel count");
	a_addr_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid && !passthru |-> CW'(addr_q) < grp_size)
		else $error("gather address outside group");

endmodule

`default_nettype wire

// ===== hw/rtl/dsd_dop_word_packer.sv =====
// top level of the dsd word packer: register port, front end, group queue and back end
//
// Input channel (in_valid/in_ready) takes one DSD byte per cycle while in_ready is
// high, channel interleaved, with buffer_start restarting the group position and
// the DoP marker. Output channel (out_valid/out_ready) gives at most one word per
// cycle with its byte count, channel and a last flag on the final word of a group
// or on every word in passthrough modes. In passthrough modes every byte is queued
// and gives one registered word. In grouped modes a group of width * channels bytes
// is copied into the queue on its last byte; the back end then gathers one byte
// per cycle, holding a word's last byte while the output register is full. That
// gather matches the input rate: one byte a cycle sustained in every mode while
// out_ready stays high. The two-entry group queue lets the input run on while the
// receiver stalls; in_ready drops only once both entries are full.
// Registers sit on an APB port at 0x0 (pack_mode), 0x4 (big_endian) and
// 0x8 (channel_count). Reset sets mode 0, little-endian, two channels, the
// group position to zero and the marker to 0x05; the group buffer itself
// holds no defined contents until written.
`default_nettype none

module dsd_dop_word_packer
	import dsdp_pkg::*;
#(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CFG_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        dsd_byte,
	input  wire logic              buffer_start,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [31:0]            out_bytes,
	output logic [2:0]             out_byte_count,
	output logic [2:0]             out_channel,
	output logic                   last
);

	localparam int GRP_DEPTH = 4 * MAX_CHANNELS;
	localparam int SNAP_W    = 8 * GRP_DEPTH;
	localparam int Q_W       = $bits(job_t) + SNAP_W;

	logic [2:0] pack_mode_q;
	logic       big_endian_q;
	logic [3:0] channel_count_q;
	logic       cfg_wr;

	logic              accept;
	logic              push, pop, q_empty, q_full;
	job_t              push_job, head_job;
	logic [SNAP_W-1:0] push_snap, head_snap;
	logic [Q_W-1:0]    head_data;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pack_mode_q     <= MODE_MSB8;
			big_endian_q    <= 1'b0;
			channel_count_q <= 4'd2;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_PACK_MODE:     pack_mode_q     <= pwdata[2:0];
				REG_BIG_ENDIAN:    big_endian_q    <= pwdata[0];
				REG_CHANNEL_COUNT: channel_count_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_PACK_MODE:     prdata = {29'd0, pack_mode_q};
			REG_BIG_ENDIAN:    prdata = {31'd0, big_endian_q};
			REG_CHANNEL_COUNT: prdata = {28'd0, channel_count_q};
			default:           prdata = 32'd0;
		endcase
	end

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	dsdp_front #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.dsd_byte     (dsd_byte),
		.buffer_start (buffer_start),
		.pack_mode    (pack_mode_q),
		.big_endian   (big_endian_q),
		.channel_count(channel_count_q),
		.push         (push),
		.push_job     (push_job),
		.push_snap    (push_snap)
	);

	dsdp_fifo #(
		.W    (Q_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_job, push_snap}),
		.pop      (pop),
		.head_data(head_data),
		.empty    (q_empty),
		.full     (q_full)
	);

	assign head_job  = head_data[Q_W-1:SNAP_W];
	assign head_snap = head_data[SNAP_W-1:0];

	dsdp_back #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (!q_empty),
		.head_job      (head_job),
		.head_snap     (head_snap),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_bytes     (out_bytes),
		.out_byte_count(out_byte_count),
		.out_channel   (out_channel),
		.last          (last)
	);

endmodule

`default_nettype wire
